[sv/rbca_pkg.sv]
// ----------------------------------------------------------------------------
// rbca_pkg
// Shared types and codes for the reorder buffer with cumulative ack.
// ----------------------------------------------------------------------------
`default_nettype none

package rbca_pkg;

	// segment types on the input
	localparam logic [1:0] ACT_DATA = 2'd0;
	localparam logic [1:0] ACT_FIN  = 2'd1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_FIN_ACK = 2'd2
	} kind_t;

	// one held segment, as stored in the buffer memory
	typedef struct packed {
		logic [30:0] seq;
		logic [15:0] handle;
		logic [10:0] size;
	} held_t;

	localparam int HELD_W = $bits(held_t);

endpackage

`default_nettype wire

[sv/rbca_ram.sv]
// ----------------------------------------------------------------------------
// rbca_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbca_ram #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[sv/reorder_buffer_cumulative_ack.sv]
// ----------------------------------------------------------------------------
// reorder_buffer_cumulative_ack
// Receiver reorder buffer: delivers in-order segments, holds future ones in a
// sorted circular buffer, drains the run that continues, and sends a
// cumulative ack per data segment. A fin ends operation until reset.
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  segment   start / busy       action, seq_number, payload_handle, payload_size
//  result    strobe (1 cycle)   kind, out_handle, out_size, ack_number,
//                               overflow, last
//
// An old or fin segment is answered from idle; an ignored one gets no result.
// An in-order segment is delivered, then the run that continues is drained:
// each held head entry is read through the registered port, then checked, up
// to an empty buffer or an entry that does not continue the run. A future
// segment is compared with the held entries in order, then stored by moving
// higher entries up and writing the new word; a full buffer flags overflow.
// The held buffer needs no clearing after reset; head pointer, count and
// expected sequence are cleared at once. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_buffer_cumulative_ack #(
	parameter int DEPTH       = 16,
	parameter int MAX_SEGMENT = 2000
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic [30:0]        seq_number,
	input  wire logic [15:0]        payload_handle,
	input  wire logic [10:0]        payload_size,
	output logic                    strobe,
	output logic [1:0]              kind,
	output logic [15:0]             out_handle,
	output logic [10:0]             out_size,
	output logic signed [31:0]      ack_number,
	output logic                    overflow,
	output logic                    last
);

	import rbca_pkg::*;

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CAP = (MAX_SEGMENT > 2047) ? 2047 : MAX_SEGMENT;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DRD,   // drain: read head entry
		S_DCHK,  // drain: check head entry
		S_SRD,   // search: read entry at idx
		S_SCHK,  // search: compare entry at idx
		S_SHRD,  // insert: read entry idx-1 or write new word
		S_SHWR   // insert: move entry up to idx
	} state_t;

	state_t        state_q;
	logic [31:0]   exp_q;     // next expected sequence number
	logic [AW-1:0] hd_q;      // physical slot of the lowest held segment
	logic [CW-1:0] cnt_q;
	logic          fin_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	held_t         seg_q;

	logic          strobe_q;
	kind_t         kind_q;
	logic [15:0]   handle_q;
	logic [10:0]   size_q;
	logic [31:0]   ack_q;
	logic          ovf_q;
	logic          last_q;

	logic          accept;
	logic [10:0]   sat_size;
	held_t         rd_word;
	logic [HELD_W-1:0] rd_raw;
	logic [CW-1:0] lk;
	logic [AW:0]   sum;
	logic [AW-1:0] phys;
	logic [31:0]   cmp_a;
	logic [31:0]   cmp_b;
	logic          cmp_eq;
	logic          cmp_lt;
	logic          we;
	held_t         wdata;
	logic [31:0]   ack_now;

	assign accept   = start && !busy;
	assign sat_size = (payload_size > 11'(CAP)) ? 11'(CAP) : payload_size;
	assign rd_word  = held_t'(rd_raw);
	assign ack_now  = exp_q - 32'd1;

	// logical slot selection for the shared address unit
	always_comb begin
		case (state_q)
			S_DRD:   lk = '0;
			S_DCHK:  lk = CW'(1);
			S_SRD:   lk = idx_q;
			S_SHRD:  lk = (idx_q == pos_q) ? pos_q : idx_q - CW'(1);
			S_SHWR:  lk = idx_q;
			default: lk = '0;
		endcase
	end

	// shared address unit: head plus logical slot, wrapped once
	assign sum  = {1'b0, hd_q} + (AW + 1)'(lk);
	assign phys = (sum >= (AW + 1)'(DEPTH)) ? AW'(sum - (AW + 1)'(DEPTH)) : AW'(sum);

	// shared sequence comparator
	always_comb begin
		cmp_a = (state_q == S_IDLE) ? {1'b0, seq_number} : {1'b0, rd_word.seq};
		cmp_b = (state_q == S_SCHK) ? {1'b0, seg_q.seq} : exp_q;
	end
	assign cmp_eq = (cmp_a == cmp_b);
	assign cmp_lt = (cmp_a < cmp_b);

	// memory write: shift entry up, or place the new word
	assign we    = (state_q == S_SHWR) || ((state_q == S_SHRD) && (idx_q == pos_q));
	assign wdata = (state_q == S_SHWR) ? rd_word : seg_q;

	rbca_ram #(
		.WIDTH (HELD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (phys),
		.wdata (wdata),
		.raddr (phys),
		.rdata (rd_raw)
	);

	// sequencer and registered result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			exp_q    <= '0;
			hd_q     <= '0;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			idx_q    <= '0;
			pos_q    <= '0;
			seg_q    <= '0;
			strobe_q <= 1'b0;
			kind_q   <= KIND_ACK;
			handle_q <= '0;
			size_q   <= '0;
			ack_q    <= '0;
			ovf_q    <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			kind_q   <= KIND_ACK;
			handle_q <= '0;
			size_q   <= '0;
			ack_q    <= '0;
			ovf_q    <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && !fin_q) begin
						seg_q <= '{seq: seq_number, handle: payload_handle, size: sat_size};
						if (action == ACT_FIN) begin
							strobe_q <= 1'b1;
							kind_q   <= KIND_FIN_ACK;
							last_q   <= 1'b1;
							fin_q    <= 1'b1;
						end else if (action == ACT_DATA) begin
							if (cmp_eq) begin
								strobe_q <= 1'b1;
								kind_q   <= KIND_DELIVER;
								handle_q <= payload_handle;
								size_q   <= sat_size;
								exp_q    <= exp_q + 32'd1;
								state_q  <= S_DRD;
							end else if (cmp_lt) begin
								strobe_q <= 1'b1;
								ack_q    <= ack_now;
								last_q   <= 1'b1;
							end else begin
								idx_q   <= '0;
								state_q <= S_SRD;
							end
						end
					end
				end
				S_DRD: begin
					if (cnt_q == '0) begin
						strobe_q <= 1'b1;
						ack_q    <= ack_now;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					if (cmp_eq) begin
						strobe_q <= 1'b1;
						kind_q   <= KIND_DELIVER;
						handle_q <= rd_word.handle;
						size_q   <= rd_word.size;
						exp_q    <= exp_q + 32'd1;
						hd_q     <= phys;
						cnt_q    <= cnt_q - CW'(1);
						state_q  <= S_DRD;
					end else begin
						strobe_q <= 1'b1;
						ack_q    <= ack_now;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SRD: begin
					if (idx_q == cnt_q) begin
						// end of list: insert at the tail unless full
						if (cnt_q == CW'(DEPTH)) begin
							strobe_q <= 1'b1;
							ack_q    <= ack_now;
							ovf_q    <= 1'b1;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							pos_q   <= idx_q;
							state_q <= S_SHRD;
						end
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (cmp_lt) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SRD;
					end else if (cmp_eq) begin
						// duplicate: drop, plain ack
						strobe_q <= 1'b1;
						ack_q    <= ack_now;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (cnt_q == CW'(DEPTH)) begin
						strobe_q <= 1'b1;
						ack_q    <= ack_now;
						ovf_q    <= 1'b1;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						pos_q   <= idx_q;
						idx_q   <= cnt_q;
						state_q <= S_SHRD;
					end
				end
				S_SHRD: begin
					if (idx_q == pos_q) begin
						cnt_q    <= cnt_q + CW'(1);
						strobe_q <= 1'b1;
						ack_q    <= ack_now;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= S_SHRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign out_handle = handle_q;
	assign out_size   = size_q;
	assign ack_number = $signed(ack_q);
	assign overflow   = ovf_q;
	assign last       = last_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("held count above depth");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe_q && last_q)
		else $error("sequence ended without a final result");

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("finished flag cleared");

	a_deliver_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (kind_q == KIND_DELIVER) |-> !last_q && busy)
		else $error("deliver marked final or outside a drain");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && ovf_q |-> (cnt_q == CW'(DEPTH)) && (kind_q == KIND_ACK))
		else $error("overflow flagged with room left");

endmodule

`default_nettype wire
